/* hdl/translation_sign_check_assert.svh */
// assertion macros for the checker file of translation_sign_check
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef TRANSLATION_SIGN_CHECK_ASSERT_SVH
`define TRANSLATION_SIGN_CHECK_ASSERT_SVH

// same-cycle implication
`define TSC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/tsc_pkg.sv */
// shared types and constants of the translation sign check block
// microcode word layout, operand selects, port widths; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int ACC_WIDTH_DEF = 48;

	localparam int COEF_W      = 16;
	localparam int IMG_W       = 16;
	localparam int PLY_W       = 20;
	localparam int REG_W       = 48;
	localparam int TOTAL_W     = 48;
	localparam int CFG_AW      = 2;
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 104;

	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] UC_FIN_STEP = STEP_W'(21);

	typedef enum logic [CFG_AW-1:0] {
		CFG_E_ROW0,
		CFG_E_ROW1,
		CFG_E_ROW2,
		CFG_T_VECTOR
	} cfg_idx_t;

	// multiplier operand a: 16-bit coefficient sources
	typedef enum logic [3:0] {
		A_E00, A_E01, A_E02,
		A_E10, A_E11, A_E12,
		A_E20, A_E21, A_E22,
		A_IMG0, A_IMG1, A_IMG2,
		A_T0, A_T1, A_T2
	} asel_t;

	// multiplier operand b: wide sources
	typedef enum logic [3:0] {
		B_PLY0, B_PLY1, B_PLY2,
		B_EX0, B_EX1, B_EX2,
		B_CR0, B_CR1, B_CR2
	} bsel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} accop_t;

	typedef enum logic [2:0] {
		D_NONE,
		D_EX0, D_EX1, D_EX2,
		D_CR0, D_CR1, D_CR2,
		D_SUM
	} dest_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_IFSKIP,
		J_END
	} jmp_t;

	typedef struct packed {
		asel_t             asel;
		bsel_t             bsel;
		accop_t            accop;
		dest_t             dest;
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
	} ucw_t;

	typedef enum logic [1:0] {
		SQ_IDLE = 2'b01,
		SQ_RUN  = 2'b10
	} seq_state_t;

	typedef struct packed {
		logic take;
		logic run;
		logic emit;
		ucw_t uc;
	} dp_ctrl_t;

	typedef struct packed {
		logic skip;
		logic fin_ok;
	} dp_stat_t;

endpackage

`default_nettype wire

/* hdl/tsc_ucode_rom.sv */
// microcode program of the sign check: one control word per step
// depends on tsc_pkg for the control word layout
`timescale 1ns / 1ps
`default_nettype none

module tsc_ucode_rom import tsc_pkg::*; (
	input  logic [STEP_W-1:0] step,
	output ucw_t              uw
);

	function automatic ucw_t mk(input asel_t a, input bsel_t b, input accop_t op,
			input dest_t d, input jmp_t j);
		ucw_t w;
		w.asel   = a;
		w.bsel   = b;
		w.accop  = op;
		w.dest   = d;
		w.jmp    = j;
		w.target = UC_FIN_STEP;
		return w;
	endfunction

	// accumulator works on the product of the previous step,
	// a store reads the accumulator as it stood before this step
	always_comb begin
		unique case (step)
			STEP_W'(0):  uw = mk(A_E00,  B_PLY0, ACC_HOLD, D_NONE, J_IFSKIP);
			STEP_W'(1):  uw = mk(A_E00,  B_PLY0, ACC_HOLD, D_NONE, J_NEXT);
			STEP_W'(2):  uw = mk(A_E01,  B_PLY1, ACC_LOAD, D_NONE, J_NEXT);
			STEP_W'(3):  uw = mk(A_E02,  B_PLY2, ACC_ADD,  D_NONE, J_NEXT);
			STEP_W'(4):  uw = mk(A_E10,  B_PLY0, ACC_ADD,  D_NONE, J_NEXT);
			STEP_W'(5):  uw = mk(A_E11,  B_PLY1, ACC_LOAD, D_EX0,  J_NEXT);
			STEP_W'(6):  uw = mk(A_E12,  B_PLY2, ACC_ADD,  D_NONE, J_NEXT);
			STEP_W'(7):  uw = mk(A_E20,  B_PLY0, ACC_ADD,  D_NONE, J_NEXT);
			STEP_W'(8):  uw = mk(A_E21,  B_PLY1, ACC_LOAD, D_EX1,  J_NEXT);
			STEP_W'(9):  uw = mk(A_E22,  B_PLY2, ACC_ADD,  D_NONE, J_NEXT);
			// cross product, z term first since ex2 is not ready yet
			STEP_W'(10): uw = mk(A_IMG0, B_EX1,  ACC_ADD,  D_NONE, J_NEXT);
			STEP_W'(11): uw = mk(A_IMG1, B_EX0,  ACC_LOAD, D_EX2,  J_NEXT);
			STEP_W'(12): uw = mk(A_IMG1, B_EX2,  ACC_SUB,  D_NONE, J_NEXT);
			STEP_W'(13): uw = mk(A_IMG2, B_EX1,  ACC_LOAD, D_CR2,  J_NEXT);
			STEP_W'(14): uw = mk(A_IMG2, B_EX0,  ACC_SUB,  D_NONE, J_NEXT);
			STEP_W'(15): uw = mk(A_IMG0, B_EX2,  ACC_LOAD, D_CR0,  J_NEXT);
			// dot product with t
			STEP_W'(16): uw = mk(A_T0,   B_CR0,  ACC_SUB,  D_NONE, J_NEXT);
			STEP_W'(17): uw = mk(A_T2,   B_CR2,  ACC_LOAD, D_CR1,  J_NEXT);
			STEP_W'(18): uw = mk(A_T1,   B_CR1,  ACC_ADD,  D_NONE, J_NEXT);
			STEP_W'(19): uw = mk(A_T1,   B_CR1,  ACC_ADD,  D_NONE, J_NEXT);
			STEP_W'(20): uw = mk(A_T1,   B_CR1,  ACC_HOLD, D_SUM,  J_NEXT);
			STEP_W'(21): uw = mk(A_T1,   B_CR1,  ACC_HOLD, D_NONE, J_END);
			default:     uw = mk(A_E00,  B_PLY0, ACC_HOLD, D_NONE, J_END);
		endcase
	end

endmodule

`default_nettype wire

/* hdl/tsc_sequencer.sv */
// step counter and jump logic that walks the microcode program per point
// depends on tsc_pkg; control word comes from tsc_ucode_rom
`timescale 1ns / 1ps
`default_nettype none

module tsc_sequencer import tsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  dp_stat_t          stat,
	input  ucw_t              uw,
	output logic [STEP_W-1:0] step,
	output dp_ctrl_t          ctrl
);

	seq_state_t        state_q;
	logic [STEP_W-1:0] step_q;

	assign s_ready   = (state_q == SQ_IDLE);
	assign step      = step_q;
	assign ctrl.take = s_valid && s_ready;
	assign ctrl.run  = (state_q == SQ_RUN);
	assign ctrl.emit = ctrl.run && (uw.jmp == J_END) && stat.fin_ok;
	assign ctrl.uc   = uw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				SQ_IDLE: begin
					if (ctrl.take) begin
						state_q <= SQ_RUN;
						step_q  <= '0;
					end
				end
				SQ_RUN: begin
					unique case (uw.jmp)
						J_NEXT:   step_q <= step_q + STEP_W'(1);
						J_IFSKIP: step_q <= stat.skip ? uw.target : step_q + STEP_W'(1);
						J_END: begin
							// hold on the last step while the result slot is taken
							if (stat.fin_ok)
								state_q <= SQ_IDLE;
						end
						default:  state_q <= SQ_IDLE;
					endcase
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/tsc_datapath.sv */
// datapath: config registers, shared multiplier, accumulator, saturating sum
// and output register; driven by the control word of tsc_sequencer, uses tsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsc_datapath import tsc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_AW-1:0]      cfg_addr,
	input  logic [REG_W-1:0]       cfg_wdata,
	input  logic [IN_TDATA_W-1:0]  s_data,
	input  logic                   s_last,
	input  dp_ctrl_t               ctrl,
	output dp_stat_t               stat,
	output logic                   m_valid,
	input  logic                   m_ready,
	output logic [OUT_TDATA_W-1:0] m_data
);

	localparam int EX_W   = COEF_W + PLY_W + 2 - FRAC_BITS;
	localparam int CR_W   = IMG_W + EX_W + 1 - FRAC_BITS;
	localparam int DOT_W  = COEF_W + CR_W + 2 - FRAC_BITS;
	localparam int MB_A   = (PLY_W > EX_W) ? PLY_W : EX_W;
	localparam int MB_W   = (MB_A > CR_W) ? MB_A : CR_W;
	localparam int PROD_W = COEF_W + MB_W;
	localparam int ACCP_W = PROD_W + 2;
	localparam int SUM_W  = ((ACC_WIDTH > DOT_W) ? ACC_WIDTH : DOT_W) + 1;
	localparam int PAD_W  = OUT_TDATA_W - 3 * COEF_W - 1 - TOTAL_W;

	localparam logic signed [ACC_WIDTH-1:0] SUM_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] SUM_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	function automatic logic [COEF_W-1:0] neg_sat(input logic [COEF_W-1:0] v);
		logic [COEF_W-1:0] most_neg;
		most_neg = {1'b1, {(COEF_W-1){1'b0}}};
		return (v == most_neg) ? ~most_neg : (~v + COEF_W'(1));
	endfunction

	logic [REG_W-1:0]            e_row_q [3];
	logic [REG_W-1:0]            t_vec_q;
	logic signed [IMG_W-1:0]     img_q [3];
	logic signed [PLY_W-1:0]     ply_q [3];
	logic                        last_q;
	logic signed [COEF_W-1:0]    mul_a;
	logic signed [MB_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]    prod_s1;
	logic signed [ACCP_W-1:0]    acc_q;
	logic signed [ACCP_W-1:0]    acc_shr;
	logic signed [EX_W-1:0]      ex_q [3];
	logic signed [CR_W-1:0]      cr_q [3];
	logic signed [DOT_W-1:0]     dot;
	logic signed [SUM_W-1:0]     sum_add;
	logic [SUM_W-ACC_WIDTH:0]    sum_top;
	logic signed [ACC_WIDTH-1:0] sum_next;
	logic signed [ACC_WIDTH-1:0] sum_q;
	logic                        first_pending_q;
	logic                        out_valid_q;
	logic                        flip;
	logic [COEF_W-1:0]           t_out_q [3];
	logic                        flipped_q;
	logic [TOTAL_W-1:0]          total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_row_q[0] <= '0;
			e_row_q[1] <= '0;
			e_row_q[2] <= '0;
			t_vec_q    <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_E_ROW0:   e_row_q[0] <= cfg_wdata;
				CFG_E_ROW1:   e_row_q[1] <= cfg_wdata;
				CFG_E_ROW2:   e_row_q[2] <= cfg_wdata;
				CFG_T_VECTOR: t_vec_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			img_q[0] <= s_data[0*IMG_W +: IMG_W];
			img_q[1] <= s_data[1*IMG_W +: IMG_W];
			img_q[2] <= s_data[2*IMG_W +: IMG_W];
			ply_q[0] <= s_data[3*IMG_W + 0*PLY_W +: PLY_W];
			ply_q[1] <= s_data[3*IMG_W + 1*PLY_W +: PLY_W];
			ply_q[2] <= s_data[3*IMG_W + 2*PLY_W +: PLY_W];
			last_q   <= s_last;
		end
	end

	always_comb begin
		case (ctrl.uc.asel)
			A_E00:   mul_a = e_row_q[0][0*COEF_W +: COEF_W];
			A_E01:   mul_a = e_row_q[0][1*COEF_W +: COEF_W];
			A_E02:   mul_a = e_row_q[0][2*COEF_W +: COEF_W];
			A_E10:   mul_a = e_row_q[1][0*COEF_W +: COEF_W];
			A_E11:   mul_a = e_row_q[1][1*COEF_W +: COEF_W];
			A_E12:   mul_a = e_row_q[1][2*COEF_W +: COEF_W];
			A_E20:   mul_a = e_row_q[2][0*COEF_W +: COEF_W];
			A_E21:   mul_a = e_row_q[2][1*COEF_W +: COEF_W];
			A_E22:   mul_a = e_row_q[2][2*COEF_W +: COEF_W];
			A_IMG0:  mul_a = img_q[0];
			A_IMG1:  mul_a = img_q[1];
			A_IMG2:  mul_a = img_q[2];
			A_T0:    mul_a = t_vec_q[0*COEF_W +: COEF_W];
			A_T1:    mul_a = t_vec_q[1*COEF_W +: COEF_W];
			A_T2:    mul_a = t_vec_q[2*COEF_W +: COEF_W];
			default: mul_a = '0;
		endcase
	end

	always_comb begin
		case (ctrl.uc.bsel)
			B_PLY0:  mul_b = MB_W'(ply_q[0]);
			B_PLY1:  mul_b = MB_W'(ply_q[1]);
			B_PLY2:  mul_b = MB_W'(ply_q[2]);
			B_EX0:   mul_b = MB_W'(ex_q[0]);
			B_EX1:   mul_b = MB_W'(ex_q[1]);
			B_EX2:   mul_b = MB_W'(ex_q[2]);
			B_CR0:   mul_b = MB_W'(cr_q[0]);
			B_CR1:   mul_b = MB_W'(cr_q[1]);
			B_CR2:   mul_b = MB_W'(cr_q[2]);
			default: mul_b = '0;
		endcase
	end

	// floor shift of the exact stage sum
	assign acc_shr = acc_q >>> FRAC_BITS;
	assign dot     = acc_shr[DOT_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.run) begin
			prod_s1 <= mul_a * mul_b;
			case (ctrl.uc.accop)
				ACC_LOAD: acc_q <= ACCP_W'(prod_s1);
				ACC_ADD:  acc_q <= acc_q + ACCP_W'(prod_s1);
				ACC_SUB:  acc_q <= acc_q - ACCP_W'(prod_s1);
				default:  acc_q <= acc_q;
			endcase
			case (ctrl.uc.dest)
				D_EX0:   ex_q[0] <= acc_shr[EX_W-1:0];
				D_EX1:   ex_q[1] <= acc_shr[EX_W-1:0];
				D_EX2:   ex_q[2] <= acc_shr[EX_W-1:0];
				D_CR0:   cr_q[0] <= acc_shr[CR_W-1:0];
				D_CR1:   cr_q[1] <= acc_shr[CR_W-1:0];
				D_CR2:   cr_q[2] <= acc_shr[CR_W-1:0];
				default: ;
			endcase
		end
	end

	// saturating add: overflow when the sign bit and the bits above it disagree
	assign sum_add  = SUM_W'(sum_q) + SUM_W'(dot);
	assign sum_top  = sum_add[SUM_W-1:ACC_WIDTH-1];
	assign sum_next = (!(&sum_top) && (|sum_top)) ?
		(sum_add[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum_add[ACC_WIDTH-1:0];

	assign flip = sum_q[ACC_WIDTH-1] || (sum_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q           <= '0;
			first_pending_q <= 1'b1;
			out_valid_q     <= 1'b0;
		end else begin
			if (m_valid && m_ready)
				out_valid_q <= 1'b0;
			if (ctrl.run && (ctrl.uc.jmp == J_IFSKIP))
				first_pending_q <= 1'b0;
			if (ctrl.run && (ctrl.uc.dest == D_SUM))
				sum_q <= sum_next;
			if (ctrl.emit && last_q) begin
				out_valid_q     <= 1'b1;
				sum_q           <= '0;
				first_pending_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && last_q) begin
			for (int i = 0; i < 3; i++) begin
				t_out_q[i] <= flip ? neg_sat(t_vec_q[i*COEF_W +: COEF_W])
				                   : t_vec_q[i*COEF_W +: COEF_W];
			end
			flipped_q <= flip;
			total_q   <= TOTAL_W'(sum_q);
		end
	end

	assign stat.skip   = first_pending_q || img_q[1][IMG_W-1] || ply_q[1][PLY_W-1];
	assign stat.fin_ok = !last_q || !out_valid_q || m_ready;

	assign m_valid = out_valid_q;
	assign m_data  = {{PAD_W{1'b0}}, total_q, flipped_q, t_out_q[2], t_out_q[1], t_out_q[0]};

endmodule

`default_nettype wire

/* hdl/translation_sign_check.sv */
// Translation sign check, top level.
// Input stream: one point correspondence per transfer, tlast marks the last
// point of a set. Output stream: one result per set, sent after its last point.
// Config port: e_row0..2 at index 0..2, t_vector at index 3; write only while idle.
// Each point is taken into an input register, then a microcode program of
// 22 steps runs it through one shared 16 x 27 bit multiplier and a product
// accumulator (E*ply, cross product, dot with t, saturating sum).
// A new point is taken only once the program of the one before has ended;
// a skipped point (first of a set or negative y) jumps from the first step
// to the last. The multiplier does its 18 products in sequence.
// The result is registered when the program of a set's last point ends,
// be that point counted or skipped.
// A finished result waits in the output register; if it has not been taken
// when the next set ends, the program holds on its last step until it is.
// Reset clears the config registers, the running sum and the output valid;
// the next point after reset starts a new set.
// Uses tsc_pkg, tsc_ucode_rom, tsc_sequencer, tsc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module translation_sign_check import tsc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_AW-1:0]      cfg_addr,
	input  logic [REG_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// img_x, img_y, img_z (16 each), ply_x, ply_y, ply_z (20 each), zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// last_point
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// t_out_x, t_out_y, t_out_z (16 each), flipped (1), sign_total (48), zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [STEP_W-1:0] step;
	ucw_t              uw;
	dp_ctrl_t          ctrl;
	dp_stat_t          stat;

	tsc_ucode_rom u_rom (
		.step (step),
		.uw   (uw)
	);

	tsc_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.stat    (stat),
		.uw      (uw),
		.step    (step),
		.ctrl    (ctrl)
	);

	tsc_datapath #(
		.FRAC_BITS (FRAC_BITS),
		.ACC_WIDTH (ACC_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_data    (s_axis_tdata),
		.s_last    (s_axis_tlast),
		.ctrl      (ctrl),
		.stat      (stat),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_axis_tdata)
	);

endmodule

`default_nettype wire

/* hdl/tsc_checker.sv */
// port-level checks of translation_sign_check, attached by bind
// depends on tsc_pkg and translation_sign_check_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "translation_sign_check_assert.svh"

module tsc_checker import tsc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// one point at a time: busy right after an input transfer
	`TSC_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a point is in work")

	// a result appears only out of a running program
	`TSC_ASSERT_SAME(a_result_from_run, $rose(m_axis_tvalid), $past(!s_axis_tready), "result raised while idle")

	// even a skipped point gives no result in the cycle right after its input transfer
	`TSC_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result one cycle after input transfer")

	`TSC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind translation_sign_check tsc_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* dv/translation_sign_check_tb.sv */
// self-checking testbench for translation_sign_check: stream stimulus, random stalls
// on both sides, an in-bench cheirality sum predictor and a per-field result checker
// depends on tsc_pkg and translation_sign_check
`timescale 1ns / 1ps

module translation_sign_check_tb import tsc_pkg::*; ();

	localparam int SETTLE_CYCLES = 32;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int PHASE_POINTS  = 200;
	localparam longint SUM_MAX   = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;
	localparam longint SUM_MIN   = -SUM_MAX - 1;

	typedef struct {
		logic signed [15:0] img_x;
		logic signed [15:0] img_y;
		logic signed [15:0] img_z;
		logic signed [19:0] ply_x;
		logic signed [19:0] ply_y;
		logic signed [19:0] ply_z;
		logic               last_point;
	} point_t;

	typedef struct {
		logic signed [15:0] t_out_x;
		logic signed [15:0] t_out_y;
		logic signed [15:0] t_out_z;
		logic               flipped;
		logic [47:0]        sign_total;
	} verdict_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wen;
	logic [CFG_AW-1:0]      cfg_addr;
	logic [REG_W-1:0]       cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// predictor copy of the block's registers and running state
	logic [47:0] e_rows [3];
	logic [47:0] t_reg;
	longint      run_sum;
	bit          skip_next;

	verdict_t    pending_verdicts [$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          steady_send;

	translation_sign_check i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint coef(input logic [47:0] r, input int k);
		logic signed [15:0] c;
		c = r[16*k +: 16];
		return c;
	endfunction

	function automatic longint sat_sum(input longint a, input longint b);
		if (b > 0 && a > SUM_MAX - b) return SUM_MAX;
		if (b < 0 && a < SUM_MIN - b) return SUM_MIN;
		return a + b;
	endfunction

	// negation of a Q1.14 entry, -32768 saturates
	function automatic logic [15:0] steer(input longint v, input bit flip);
		if (!flip) return 16'(v);
		if (v == -32768) return 16'h7FFF;
		return 16'(-v);
	endfunction

	// folds one accepted point into the running sum; returns 1 when it closes a set
	function automatic bit fold_point(input point_t pt, output verdict_t res);
		longint img [3];
		longint ply [3];
		longint tv [3];
		longint ex [3];
		longint cr [3];
		longint s;
		bit     flip;
		int     i;
		img[0] = pt.img_x; img[1] = pt.img_y; img[2] = pt.img_z;
		ply[0] = pt.ply_x; ply[1] = pt.ply_y; ply[2] = pt.ply_z;
		for (i = 0; i < 3; i++)
			tv[i] = coef(t_reg, i);
		res = '{default: '0};
		if (skip_next) begin
			skip_next = 1'b0;
		end else if (img[1] >= 0 && ply[1] >= 0) begin
			for (i = 0; i < 3; i++) begin
				s = coef(e_rows[i], 0) * ply[0] + coef(e_rows[i], 1) * ply[1]
					+ coef(e_rows[i], 2) * ply[2];
				ex[i] = s >>> FRAC_BITS_DEF;
			end
			cr[0] = (img[1] * ex[2] - img[2] * ex[1]) >>> FRAC_BITS_DEF;
			cr[1] = (img[2] * ex[0] - img[0] * ex[2]) >>> FRAC_BITS_DEF;
			cr[2] = (img[0] * ex[1] - img[1] * ex[0]) >>> FRAC_BITS_DEF;
			s = (tv[0] * cr[0] + tv[1] * cr[1] + tv[2] * cr[2]) >>> FRAC_BITS_DEF;
			run_sum = sat_sum(run_sum, s);
		end
		if (!pt.last_point) return 1'b0;
		flip = !(run_sum > 0);
		res.t_out_x    = steer(tv[0], flip);
		res.t_out_y    = steer(tv[1], flip);
		res.t_out_z    = steer(tv[2], flip);
		res.flipped    = flip;
		res.sign_total = run_sum[47:0];
		run_sum   = 0;
		skip_next = 1'b1;
		return 1'b1;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int rand_in(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int pick(input int lo, input int hi);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return lo;
		if (r == 1) return hi;
		if (r == 2) return 0;
		return rand_in(lo, hi);
	endfunction

	function automatic point_t mk_point(input int ix, input int iy, input int iz,
			input int px, input int py, input int pz, input bit last);
		point_t pt;
		pt.img_x = 16'(ix); pt.img_y = 16'(iy); pt.img_z = 16'(iz);
		pt.ply_x = 20'(px); pt.ply_y = 20'(py); pt.ply_z = 20'(pz);
		pt.last_point = last;
		return pt;
	endfunction

	// y components are mostly non-negative so that most points count
	function automatic point_t rand_point(input bit last);
		int iy, py;
		iy = ($urandom_range(0, 4) == 0) ? pick(-16384, -1) : pick(0, 16384);
		py = ($urandom_range(0, 4) == 0) ? pick(-524288, -1) : pick(0, 524287);
		return mk_point(pick(-16384, 16384), iy, pick(-16384, 16384),
			pick(-524288, 524287), py, pick(-524288, 524287), last);
	endfunction

	task automatic note_mismatch(input string field, input longint want, input longint got);
		mismatch_count++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// result checker
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.t_out_x    = m_axis_tdata[15:0];
			got.t_out_y    = m_axis_tdata[31:16];
			got.t_out_z    = m_axis_tdata[47:32];
			got.flipped    = m_axis_tdata[48];
			got.sign_total = m_axis_tdata[96:49];
			if (pending_verdicts.size() == 0) begin
				note_mismatch("unexpected result transfer, sign_total", 0, got.sign_total);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.t_out_x !== want.t_out_x)
					note_mismatch("t_out_x", want.t_out_x, got.t_out_x);
				if (got.t_out_y !== want.t_out_y)
					note_mismatch("t_out_y", want.t_out_y, got.t_out_y);
				if (got.t_out_z !== want.t_out_z)
					note_mismatch("t_out_z", want.t_out_z, got.t_out_z);
				if (got.flipped !== want.flipped)
					note_mismatch("flipped", want.flipped, got.flipped);
				if (got.sign_total !== want.sign_total)
					note_mismatch("sign_total", want.sign_total, got.sign_total);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	// output side back-pressure, with stretches of no stall at all
	initial begin
		int run_len;
		int stall_len;
		m_axis_tready = 1'b0;
		@(negedge clk);
		forever begin
			run_len   = $urandom_range(1, 12);
			stall_len = pause_len();
			m_axis_tready = 1'b1;
			repeat (run_len) @(negedge clk);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(40, 120)) @(negedge clk);
			end else if (stall_len > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall_len) @(negedge clk);
			end
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [47:0] val);
		cfg_wen   = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		case (idx)
			CFG_E_ROW0:   e_rows[0] = val;
			CFG_E_ROW1:   e_rows[1] = val;
			CFG_E_ROW2:   e_rows[2] = val;
			CFG_T_VECTOR: t_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	task automatic load_config(input logic [47:0] r0, input logic [47:0] r1,
			input logic [47:0] r2, input logic [47:0] tv);
		write_reg(CFG_E_ROW0, r0);
		write_reg(CFG_E_ROW1, r1);
		write_reg(CFG_E_ROW2, r2);
		write_reg(CFG_T_VECTOR, tv);
	endtask

	task automatic wait_results();
		s_axis_tvalid = 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
	endtask

	// results drained and the last skipped or counted point worked off
	task automatic settle_idle();
		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// one input transfer; called and returns at a falling edge
	task automatic send_point(input point_t pt);
		int       gap;
		verdict_t res;
		gap = steady_send ? 0 : pause_len();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {4'b0, pt.ply_z, pt.ply_y, pt.ply_x, pt.img_z, pt.img_y, pt.img_x};
		s_axis_tlast  = pt.last_point;
		do @(posedge clk); while (!s_axis_tready);
		if (fold_point(pt, res))
			pending_verdicts = {pending_verdicts, res};
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic send_set(input int len);
		int n;
		for (n = 0; n < len; n++)
			send_point(rand_point(n == len - 1));
	endtask

	// zero registers from reset: sum stays zero, so every set flips a zero t
	task automatic test_reset_defaults();
		send_point(mk_point(16384, 16384, -16384, 524287, 524287, -524288, 1'b1));
		send_point(mk_point(100, 200, 300, 1000, 2000, 3000, 1'b0));
		send_point(mk_point(-16384, 0, 16384, -524288, 0, 524287, 1'b0));
		send_point(mk_point(1, 1, 1, 1, 1, 1, 1'b1));
	endtask

	// points with a negative y component add nothing; y of zero still counts
	task automatic test_negative_y();
		settle_idle();
		load_config(48'h1000_2000_4000, 48'hE000_4000_0800, 48'h3000_C000_2000,
			48'h2000_E000_3000);
		send_point(mk_point(9000, 9000, 9000, 300000, 300000, 300000, 1'b0));
		send_point(mk_point(12000, -1, 5000, 400000, 200000, -100000, 1'b0));
		send_point(mk_point(-7000, 3000, 16384, 250000, -1, 90000, 1'b0));
		send_point(mk_point(16384, -16384, -16384, 524287, -524288, 524287, 1'b0));
		send_point(mk_point(-16384, -200, 8000, -524288, -70000, 0, 1'b1));
		send_point(mk_point(4000, 0, -9000, 100000, 0, 50000, 1'b0));
		send_point(mk_point(16384, 0, -16384, 524287, 0, -524288, 1'b1));
	endtask

	// full-scale coefficients and fields; t holds -32768 so negation saturates
	task automatic test_field_extremes();
		settle_idle();
		load_config(48'h7FFF_8000_7FFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
			48'h8000_7FFF_8000);
		send_point(mk_point(-16384, 16384, -16384, -524288, 524287, -524288, 1'b0));
		send_point(mk_point(16384, 16384, 16384, 524287, 524287, 524287, 1'b0));
		send_point(mk_point(-16384, 16384, 16384, -524288, 524287, 524287, 1'b0));
		send_point(mk_point(16384, 0, -16384, 524287, 0, -524288, 1'b0));
		send_point(mk_point(-16384, 16384, 0, 0, 524287, -524288, 1'b1));
		send_point(mk_point(16384, 16384, 16384, 524287, 524287, 524287, 1'b1));
		// mirrored pair: the ply sign swap turns the sum around
		send_point(mk_point(0, 0, 0, 0, 0, 0, 1'b0));
		send_point(mk_point(16384, 8192, -16384, 524287, 0, 524287, 1'b1));
		send_point(mk_point(0, 0, 0, 0, 0, 0, 1'b0));
		send_point(mk_point(16384, 8192, -16384, -524287, 0, -524287, 1'b1));
	endtask

	task automatic test_random_sets();
		int phase;
		int sent;
		int len;
		for (phase = 0; phase < 6; phase++) begin
			settle_idle();
			case (phase)
				0: load_config(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
					48'hFFFF_FFFF_FFFF);
				1: load_config(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h0,
					48'h4000_C000_4000);
				default: load_config({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			endcase
			sent = 0;
			while (sent < PHASE_POINTS) begin
				len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
				steady_send = ($urandom_range(0, 4) == 0);
				send_set(len);
				sent += len;
				// now and then the sender holds off until every result is back
				if ($urandom_range(0, 11) == 0)
					wait_results();
			end
			steady_send = 1'b0;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		e_rows[0]     = '0;
		e_rows[1]     = '0;
		e_rows[2]     = '0;
		t_reg         = '0;
		run_sum       = 0;
		skip_next     = 1'b1;
		steady_send   = 1'b0;
		mismatch_count = 0;
		cycle_count   = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_negative_y();
		test_field_extremes();
		test_random_sets();

		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
